/* rtl/interval_set_merge_subtract_macros.svh */
// assertion macros used by the interval set top level
`ifndef INTERVAL_SET_MERGE_SUBTRACT_MACROS_SVH
`define INTERVAL_SET_MERGE_SUBTRACT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ISMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ISMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/isms_pkg.sv */
// types and constants of the interval set block
`default_nettype none
package isms_pkg;

    localparam int ID_W        = 48;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] KIND_LOAD_A = 3'd0;
    localparam logic [2:0] KIND_LOAD_B = 3'd1;
    localparam logic [2:0] KIND_DIFF   = 3'd2;
    localparam logic [2:0] KIND_UNION  = 3'd3;
    localparam logic [2:0] KIND_CLEAR  = 3'd4;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] start_value;
        logic [ID_W-1:0] end_value;
    } t_cmd;

    typedef struct packed {
        logic [ID_W-1:0] range_start;
        logic [ID_W-1:0] range_end;
        logic            last_of_run;
        logic            empty_set;
        logic            overflowed;
    } t_res;

endpackage
`default_nettype wire

/* rtl/interval_set_merge_subtract.sv */
// top level: two sorted interval stores with coalesce, difference and union emit
//
// one command channel: a beat is taken when start is high and busy is low.
// kind selects load a, load b, emit a minus b, emit union or clear.
// loads insert into a sorted ram by shifting larger entries up one slot at a time;
// reversed loads, loads into a full store and clear finish in the accepting cycle.
// an emit first coalesces store a then store b in place, then walks both rams,
// visiting a and b intervals for the difference and merged intervals for the
// union, and S_FIN puts out the final beat.
// results leave on o_res with o_valid high for exactly one cycle each, in
// ascending order; the final one carries last_of_run, an empty set gives a
// single beat with empty_set set. at most 32 beats leave per emit.
// the receiver cannot stall, so no beat waits on the receiver.
// busy stays high from acceptance; after an emit it drops in the cycle the final beat is on o_res.
// reset (synchronous, active low) empties both stores and clears the
// overflow flag; ram contents are not cleared, the counts guard all reads.
`default_nettype none
`include "interval_set_merge_subtract_macros.svh"
module interval_set_merge_subtract #(
    parameter int SET_CAPACITY = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire isms_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    output isms_pkg::t_res       o_res
);

    localparam int ID_WIDTH = isms_pkg::ID_W;
    localparam int AW = $clog2(SET_CAPACITY);
    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int DW = 2 * ID_WIDTH;
    localparam int XW = ID_WIDTH + 1;
    localparam int OW = isms_pkg::ID_W;
    localparam int RW = isms_pkg::RES_CW;

    typedef enum logic [3:0] {
        S_IDLE, S_IN_RD, S_IN_CMP,
        S_CO_RD0, S_CO_LD, S_CO_RD, S_CO_STEP,
        S_DF_RDA, S_DF_LDA, S_DF_RDB, S_DF_CMPB,
        S_UN_RD, S_UN_CMP, S_UN_FLUSH, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic r_sel, n_sel;             // 0 store a, 1 store b
    logic r_union, n_union;
    logic [ID_WIDTH-1:0] r_s, n_s, r_e, n_e;
    logic [CW-1:0] r_pos, n_pos, r_i, n_i, r_j, n_j, r_w, n_w;
    logic [CW-1:0] r_a_cnt, n_a_cnt, r_b_cnt, n_b_cnt;
    logic r_ovf, n_ovf;
    logic [ID_WIDTH-1:0] r_cs, n_cs, r_ce, n_ce, r_hi, n_hi;
    logic [XW-1:0] r_cur, n_cur;
    logic r_have, n_have;
    logic r_pend_v, n_pend_v;
    logic [ID_WIDTH-1:0] r_pend_s, n_pend_s, r_pend_e, n_pend_e;
    logic [RW-1:0] r_nres, n_nres;
    isms_pkg::t_res n_res;
    logic n_valid;

    // ram ports
    logic wr_en;
    logic [AW-1:0] wr_addr, ra_a, ra_b;
    logic [DW-1:0] wr_data, rd_a, rd_b, rd_sel;
    logic [ID_WIDTH-1:0] as_v, ae_v, bs_v, be_v, ds_v, de_v;

    // result hand-off into the pending slot
    logic put_req;
    logic [ID_WIDTH-1:0] put_s, put_e;

    // command decode
    logic [ID_WIDTH-1:0] in_s, in_e;
    logic [CW-1:0] sel_cnt;
    logic take_a;
    logic [ID_WIDTH-1:0] es_v, ee_v;

    isms_ram #(.WIDTH(DW), .DEPTH(SET_CAPACITY)) u_ram_a (
        .i_clk  (i_clk),
        .i_we   (wr_en & ~r_sel),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(ra_a),
        .o_rdata(rd_a)
    );

    isms_ram #(.WIDTH(DW), .DEPTH(SET_CAPACITY)) u_ram_b (
        .i_clk  (i_clk),
        .i_we   (wr_en & r_sel),
        .i_waddr(wr_addr),
        .i_wdata(wr_data),
        .i_raddr(ra_b),
        .o_rdata(rd_b)
    );

    assign in_s    = ID_WIDTH'(i_cmd.start_value);
    assign in_e    = ID_WIDTH'(i_cmd.end_value);
    assign as_v    = rd_a[DW-1:ID_WIDTH];
    assign ae_v    = rd_a[ID_WIDTH-1:0];
    assign bs_v    = rd_b[DW-1:ID_WIDTH];
    assign be_v    = rd_b[ID_WIDTH-1:0];
    assign rd_sel  = r_sel ? rd_b : rd_a;
    assign ds_v    = rd_sel[DW-1:ID_WIDTH];
    assign de_v    = rd_sel[ID_WIDTH-1:0];
    assign sel_cnt = r_sel ? r_b_cnt : r_a_cnt;
    assign busy    = (r_state != S_IDLE);

    // merge order for the union walk: a wins ties on start when its end is not larger
    assign take_a = (r_i != r_a_cnt) &&
                    ((r_j == r_b_cnt) || (as_v < bs_v) || ((as_v == bs_v) && (ae_v <= be_v)));
    assign es_v   = take_a ? as_v : bs_v;
    assign ee_v   = take_a ? ae_v : be_v;

    always_comb begin
        n_state  = r_state;
        n_sel    = r_sel;
        n_union  = r_union;
        n_s      = r_s;
        n_e      = r_e;
        n_pos    = r_pos;
        n_i      = r_i;
        n_j      = r_j;
        n_w      = r_w;
        n_a_cnt  = r_a_cnt;
        n_b_cnt  = r_b_cnt;
        n_ovf    = r_ovf;
        n_cs     = r_cs;
        n_ce     = r_ce;
        n_hi     = r_hi;
        n_cur    = r_cur;
        n_have   = r_have;
        n_pend_v = r_pend_v;
        n_pend_s = r_pend_s;
        n_pend_e = r_pend_e;
        n_nres   = r_nres;
        n_res    = o_res;
        n_valid  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = '0;
        ra_a     = '0;
        ra_b     = '0;
        put_req  = 1'b0;
        put_s    = '0;
        put_e    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_s = in_s;
                    n_e = in_e;
                    n_i = '0;
                    n_j = '0;
                    n_have   = 1'b0;
                    n_pend_v = 1'b0;
                    n_nres   = '0;
                    unique case (i_cmd.kind) inside
                        isms_pkg::KIND_LOAD_A, isms_pkg::KIND_LOAD_B: begin
                            n_sel = (i_cmd.kind == isms_pkg::KIND_LOAD_B);
                            if (in_s <= in_e) begin
                                if (i_cmd.kind == isms_pkg::KIND_LOAD_B) begin
                                    n_pos = r_b_cnt;
                                end else begin
                                    n_pos = r_a_cnt;
                                end
                                if (n_pos == CW'(SET_CAPACITY)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    n_state = S_IN_RD;
                                end
                            end
                        end
                        isms_pkg::KIND_DIFF, isms_pkg::KIND_UNION: begin
                            n_sel   = 1'b0;
                            n_union = (i_cmd.kind == isms_pkg::KIND_UNION);
                            n_state = S_CO_RD0;
                        end
                        isms_pkg::KIND_CLEAR: begin
                            n_a_cnt = '0;
                            n_b_cnt = '0;
                            n_ovf   = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end

            // sorted insert: shift larger entries up one slot at a time
            S_IN_RD: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = {r_s, r_e};
                    if (r_sel) n_b_cnt = r_b_cnt + CW'(1);
                    else       n_a_cnt = r_a_cnt + CW'(1);
                    n_state = S_IDLE;
                end else begin
                    ra_a    = AW'(r_pos - CW'(1));
                    ra_b    = AW'(r_pos - CW'(1));
                    n_state = S_IN_CMP;
                end
            end
            S_IN_CMP: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_pos);
                if ((ds_v > r_s) || ((ds_v == r_s) && (de_v > r_e))) begin
                    wr_data = rd_sel;
                    n_pos   = r_pos - CW'(1);
                    n_state = S_IN_RD;
                end else begin
                    wr_data = {r_s, r_e};
                    if (r_sel) n_b_cnt = r_b_cnt + CW'(1);
                    else       n_a_cnt = r_a_cnt + CW'(1);
                    n_state = S_IDLE;
                end
            end

            // in-place coalesce: the write slot always trails the read slot
            S_CO_RD0: begin
                ra_a = '0;
                ra_b = '0;
                if (sel_cnt == '0) begin
                    if (r_sel) begin
                        n_i     = '0;
                        n_state = r_union ? S_UN_RD : S_DF_RDA;
                    end else begin
                        n_sel = 1'b1;
                    end
                end else begin
                    n_state = S_CO_LD;
                end
            end
            S_CO_LD: begin
                n_cs    = ds_v;
                n_ce    = de_v;
                n_i     = CW'(1);
                n_w     = '0;
                n_state = S_CO_RD;
            end
            S_CO_RD: begin
                ra_a = AW'(r_i);
                ra_b = AW'(r_i);
                if (r_i == sel_cnt) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_w);
                    wr_data = {r_cs, r_ce};
                    if (r_sel) begin
                        n_b_cnt = r_w + CW'(1);
                        n_i     = '0;
                        n_state = r_union ? S_UN_RD : S_DF_RDA;
                    end else begin
                        n_a_cnt = r_w + CW'(1);
                        n_sel   = 1'b1;
                        n_state = S_CO_RD0;
                    end
                end else begin
                    n_state = S_CO_STEP;
                end
            end
            S_CO_STEP: begin
                if (XW'(ds_v) <= XW'(r_ce) + XW'(1)) begin
                    if (de_v > r_ce) n_ce = de_v;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(r_w);
                    wr_data = {r_cs, r_ce};
                    n_w     = r_w + CW'(1);
                    n_cs    = ds_v;
                    n_ce    = de_v;
                end
                n_i     = r_i + CW'(1);
                n_state = S_CO_RD;
            end

            // a minus b: two pointers, b cuts each a interval into pieces
            S_DF_RDA: begin
                ra_a = AW'(r_i);
                n_state = (r_i == r_a_cnt) ? S_FIN : S_DF_LDA;
            end
            S_DF_LDA: begin
                n_cur   = XW'(as_v);
                n_hi    = ae_v;
                n_state = S_DF_RDB;
            end
            S_DF_RDB: begin
                ra_b = AW'(r_j);
                if (r_j == r_b_cnt) begin
                    if (r_cur <= XW'(r_hi)) begin
                        put_req = 1'b1;
                        put_s   = ID_WIDTH'(r_cur);
                        put_e   = r_hi;
                    end
                    n_i     = r_i + CW'(1);
                    n_state = S_DF_RDA;
                end else begin
                    n_state = S_DF_CMPB;
                end
            end
            S_DF_CMPB: begin
                if (XW'(be_v) < r_cur) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_DF_RDB;
                end else if (bs_v <= r_hi) begin
                    if (XW'(bs_v) > r_cur) begin
                        put_req = 1'b1;
                        put_s   = ID_WIDTH'(r_cur);
                        put_e   = bs_v - ID_WIDTH'(1);
                    end
                    n_cur = XW'(be_v) + XW'(1);
                    if (be_v >= r_hi) begin
                        n_i     = r_i + CW'(1);
                        n_state = S_DF_RDA;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_DF_RDB;
                    end
                end else begin
                    if (r_cur <= XW'(r_hi)) begin
                        put_req = 1'b1;
                        put_s   = ID_WIDTH'(r_cur);
                        put_e   = r_hi;
                    end
                    n_i     = r_i + CW'(1);
                    n_state = S_DF_RDA;
                end
            end

            // union: merge both rams by start and coalesce on the fly
            S_UN_RD: begin
                ra_a = AW'(r_i);
                ra_b = AW'(r_j);
                if ((r_i == r_a_cnt) && (r_j == r_b_cnt)) begin
                    n_state = S_UN_FLUSH;
                end else begin
                    n_state = S_UN_CMP;
                end
            end
            S_UN_CMP: begin
                if (take_a) n_i = r_i + CW'(1);
                else        n_j = r_j + CW'(1);
                if (!r_have) begin
                    n_have = 1'b1;
                    n_cs   = es_v;
                    n_ce   = ee_v;
                end else if (XW'(es_v) <= XW'(r_ce) + XW'(1)) begin
                    if (ee_v > r_ce) n_ce = ee_v;
                end else begin
                    put_req = 1'b1;
                    put_s   = r_cs;
                    put_e   = r_ce;
                    n_cs    = es_v;
                    n_ce    = ee_v;
                end
                n_state = S_UN_RD;
            end
            S_UN_FLUSH: begin
                if (r_have) begin
                    put_req = 1'b1;
                    put_s   = r_cs;
                    put_e   = r_ce;
                end
                n_state = S_FIN;
            end

            // final beat: the held result with the last mark, or the empty marker
            S_FIN: begin
                n_valid           = 1'b1;
                n_res.last_of_run = 1'b1;
                n_res.overflowed  = r_ovf;
                if (r_pend_v) begin
                    n_res.range_start = OW'(r_pend_s);
                    n_res.range_end   = OW'(r_pend_e);
                    n_res.empty_set   = 1'b0;
                end else begin
                    n_res.range_start = '0;
                    n_res.range_end   = '0;
                    n_res.empty_set   = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // one result is held back so the last mark can go on the final beat
        if (put_req && (r_nres != RW'(isms_pkg::MAX_RESULTS))) begin
            if (r_pend_v) begin
                n_valid           = 1'b1;
                n_res.range_start = OW'(r_pend_s);
                n_res.range_end   = OW'(r_pend_e);
                n_res.last_of_run = 1'b0;
                n_res.empty_set   = 1'b0;
                n_res.overflowed  = r_ovf;
            end
            n_pend_v = 1'b1;
            n_pend_s = put_s;
            n_pend_e = put_e;
            n_nres   = r_nres + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_a_cnt  <= '0;
            r_b_cnt  <= '0;
            r_ovf    <= 1'b0;
            r_pend_v <= 1'b0;
            r_have   <= 1'b0;
            r_nres   <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_a_cnt  <= n_a_cnt;
            r_b_cnt  <= n_b_cnt;
            r_ovf    <= n_ovf;
            r_pend_v <= n_pend_v;
            r_have   <= n_have;
            r_nres   <= n_nres;
            o_valid  <= n_valid;
        end
        r_sel    <= n_sel;
        r_union  <= n_union;
        r_s      <= n_s;
        r_e      <= n_e;
        r_pos    <= n_pos;
        r_i      <= n_i;
        r_j      <= n_j;
        r_w      <= n_w;
        r_cs     <= n_cs;
        r_ce     <= n_ce;
        r_hi     <= n_hi;
        r_cur    <= n_cur;
        r_pend_s <= n_pend_s;
        r_pend_e <= n_pend_e;
        o_res    <= n_res;
    end

    `ISMS_ASSERT_NOW(a_beat_from_work, i_clk, i_rst_n, o_valid, $past(r_state != S_IDLE), "beat without an emit in progress")
    `ISMS_ASSERT_NOW(a_empty_is_last, i_clk, i_rst_n, o_valid && o_res.empty_set, o_res.last_of_run, "empty marker without last mark")
    `ISMS_ASSERT_NOW(a_counts_fit, i_clk, i_rst_n, 1'b1, (r_a_cnt <= CW'(SET_CAPACITY)) && (r_b_cnt <= CW'(SET_CAPACITY)), "store count beyond capacity")
    `ISMS_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, start && !busy && (i_cmd.kind == isms_pkg::KIND_CLEAR), (r_a_cnt == '0) && (r_b_cnt == '0) && !r_ovf, "clear left state behind")

endmodule
`default_nettype wire

/* rtl/isms_ram.sv */
// generic single-write, single-read ram with registered read
`default_nettype none
module isms_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking testbench for the interval set merge and subtract block
`timescale 1ns / 1ps
module testbench;

    localparam int CAP = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int IW = isms_pkg::ID_W;
    localparam logic [IW-1:0] ID_MAX = {IW{1'b1}};
    localparam logic [2:0] KIND_UNUSED = 3'd5;
    localparam logic [2:0] KIND_SPARE  = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    isms_pkg::t_cmd i_cmd;
    logic o_valid;
    isms_pkg::t_res o_res;

    interval_set_merge_subtract u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .o_valid(o_valid), .o_res(o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // shadow copy of both interval stores
    logic [IW-1:0] a_lo [CAP];
    logic [IW-1:0] a_hi [CAP];
    logic [IW-1:0] b_lo [CAP];
    logic [IW-1:0] b_hi [CAP];
    int a_num, b_num;
    logic ovf;

    isms_pkg::t_res expected_ranges[$];
    int fail_count;
    int idle_cycles;
    int send_idle_pct;
    logic check_explicit;
    isms_pkg::t_res typed_res;

    // sorted insert; reversed intervals drop, a full store sets the flag
    task automatic store_add(bit to_b, logic [IW-1:0] s, logic [IW-1:0] e);
        int pos;
        if (s > e) return;
        if ((to_b ? b_num : a_num) >= CAP) begin
            ovf = 1'b1;
            return;
        end
        if (!to_b) begin
            pos = a_num;
            while (pos > 0 && (a_lo[pos-1] > s || (a_lo[pos-1] == s && a_hi[pos-1] > e))) begin
                a_lo[pos] = a_lo[pos-1]; a_hi[pos] = a_hi[pos-1]; pos--;
            end
            a_lo[pos] = s; a_hi[pos] = e; a_num++;
        end else begin
            pos = b_num;
            while (pos > 0 && (b_lo[pos-1] > s || (b_lo[pos-1] == s && b_hi[pos-1] > e))) begin
                b_lo[pos] = b_lo[pos-1]; b_hi[pos] = b_hi[pos-1]; pos--;
            end
            b_lo[pos] = s; b_hi[pos] = e; b_num++;
        end
    endtask

    // join overlapping or touching intervals of a sorted list
    function automatic int join_sorted(ref logic [IW-1:0] lo[$], ref logic [IW-1:0] hi[$]);
        int w;
        w = 0;
        if (lo.size() == 0) return 0;
        for (int i = 1; i < lo.size(); i++) begin
            if ({1'b0, lo[i]} <= {1'b0, hi[w]} + (IW+1)'(1)) begin
                if (hi[i] > hi[w]) hi[w] = hi[i];
            end else begin
                w++; lo[w] = lo[i]; hi[w] = hi[i];
            end
        end
        return w + 1;
    endfunction

    task automatic push_range(ref isms_pkg::t_res rq[$], input logic [IW-1:0] s,
                              logic [IW-1:0] e);
        isms_pkg::t_res r;
        if (rq.size() >= isms_pkg::MAX_RESULTS) return;
        r = '0;
        r.range_start = s; r.range_end = e; r.overflowed = ovf;
        rq.push_back(r);
    endtask

    task automatic compact_stores();
        logic [IW-1:0] lo[$], hi[$];
        int n;
        lo = {}; hi = {};
        for (int i = 0; i < a_num; i++) begin lo.push_back(a_lo[i]); hi.push_back(a_hi[i]); end
        n = join_sorted(lo, hi);
        for (int i = 0; i < n; i++) begin a_lo[i] = lo[i]; a_hi[i] = hi[i]; end
        a_num = n;
        lo = {}; hi = {};
        for (int i = 0; i < b_num; i++) begin lo.push_back(b_lo[i]); hi.push_back(b_hi[i]); end
        n = join_sorted(lo, hi);
        for (int i = 0; i < n; i++) begin b_lo[i] = lo[i]; b_hi[i] = hi[i]; end
        b_num = n;
    endtask

    // expected beats of one emit command, appended to expected_ranges
    task automatic predict_emit(logic [2:0] kind);
        isms_pkg::t_res rq[$];
        isms_pkg::t_res r;
        logic [IW:0] cur;
        logic [IW-1:0] lo[$], hi[$];
        int i, j, n;
        bit take_a, done;
        rq = {};
        compact_stores();
        if (kind == isms_pkg::KIND_DIFF) begin
            j = 0;
            for (i = 0; i < a_num; i++) begin
                cur = {1'b0, a_lo[i]};
                done = 0;
                while (j < b_num && {1'b0, b_hi[j]} < cur) j++;
                while (j < b_num && b_lo[j] <= a_hi[i]) begin
                    if ({1'b0, b_lo[j]} > cur)
                        push_range(rq, cur[IW-1:0], b_lo[j] - IW'(1));
                    cur = {1'b0, b_hi[j]} + (IW+1)'(1);
                    if (b_hi[j] >= a_hi[i]) begin done = 1; break; end
                    j++;
                end
                if (!done && cur <= {1'b0, a_hi[i]}) push_range(rq, cur[IW-1:0], a_hi[i]);
            end
        end else begin
            i = 0; j = 0; lo = {}; hi = {};
            while (i < a_num || j < b_num) begin
                if (i >= a_num) take_a = 0;
                else if (j >= b_num) take_a = 1;
                else take_a = a_lo[i] < b_lo[j] || (a_lo[i] == b_lo[j] && a_hi[i] <= b_hi[j]);
                if (take_a) begin lo.push_back(a_lo[i]); hi.push_back(a_hi[i]); i++; end
                else begin lo.push_back(b_lo[j]); hi.push_back(b_hi[j]); j++; end
            end
            n = join_sorted(lo, hi);
            for (int m = 0; m < n; m++) push_range(rq, lo[m], hi[m]);
        end
        if (rq.size() == 0) begin
            r = '0; r.last_of_run = 1'b1; r.empty_set = 1'b1; r.overflowed = ovf;
            rq.push_back(r);
        end else begin
            rq[rq.size()-1].last_of_run = 1'b1;
        end
        foreach (rq[k]) expected_ranges.push_back(rq[k]);
    endtask

    task automatic predict_command(isms_pkg::t_cmd c);
        case (c.kind) inside
            isms_pkg::KIND_LOAD_A: store_add(1'b0, c.start_value, c.end_value);
            isms_pkg::KIND_LOAD_B: store_add(1'b1, c.start_value, c.end_value);
            isms_pkg::KIND_DIFF, isms_pkg::KIND_UNION: predict_emit(c.kind);
            isms_pkg::KIND_CLEAR: begin a_num = 0; b_num = 0; ovf = 1'b0; end
            default: ;
        endcase
    endtask

    // result checker: the receiver never stalls, every strobe is a beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_ranges.size() == 0) begin
                $error("unexpected result beat start=%h end=%h", o_res.range_start,
                       o_res.range_end);
                fail_count++;
            end else begin
                isms_pkg::t_res x;
                x = expected_ranges.pop_front();
                if (o_res.range_start !== x.range_start) begin
                    $error("range_start expected %h actual %h", x.range_start, o_res.range_start);
                    fail_count++;
                end
                if (o_res.range_end !== x.range_end) begin
                    $error("range_end expected %h actual %h", x.range_end, o_res.range_end);
                    fail_count++;
                end
                if (o_res.last_of_run !== x.last_of_run) begin
                    $error("last_of_run expected %b actual %b", x.last_of_run, o_res.last_of_run);
                    fail_count++;
                end
                if (o_res.empty_set !== x.empty_set) begin
                    $error("empty_set expected %b actual %b", x.empty_set, o_res.empty_set);
                    fail_count++;
                end
                if (o_res.overflowed !== x.overflowed) begin
                    $error("overflowed expected %b actual %b", x.overflowed, o_res.overflowed);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles with no beat taken on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // send one command beat; start drops only when the sender idles first
    task automatic send_command(isms_pkg::t_cmd c);
        if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99, 0) < send_idle_pct) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(c);
    endtask

    function automatic isms_pkg::t_cmd mk(logic [2:0] k, logic [IW-1:0] s, logic [IW-1:0] e);
        isms_pkg::t_cmd c;
        c.kind = k; c.start_value = s; c.end_value = e;
        return c;
    endfunction

    function automatic logic [IW-1:0] rand_id();
        return IW'({$urandom, $urandom});
    endfunction

    // interval endpoints clustered so that overlaps and adjacency are common
    function automatic logic [IW-1:0] pick_id(logic [IW-1:0] base);
        case ($urandom_range(9, 0))
            0: return rand_id();
            1: return ID_MAX - IW'($urandom_range(40, 0));
            default: return base + IW'($urandom_range(60, 0));
        endcase
    endfunction

    function automatic isms_pkg::t_cmd random_load(logic [IW-1:0] base);
        logic [IW-1:0] s, e;
        s = pick_id(base);
        e = ($urandom_range(9, 0) == 0) ? pick_id(base) : s + IW'($urandom_range(12, 0));
        if (e < s && $urandom_range(3, 0) != 0) e = s;
        return mk($urandom_range(1, 0) ? isms_pkg::KIND_LOAD_B : isms_pkg::KIND_LOAD_A, s, e);
    endfunction

    isms_pkg::t_cmd directed_rows[$];
    int phase_sel;
    logic [IW-1:0] base;

    initial begin
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 20;
        a_num = 0; b_num = 0; ovf = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // after reset: empty union typed in by hand
        send_command(mk(isms_pkg::KIND_UNION, '0, '0));
        typed_res = '0; typed_res.last_of_run = 1'b1; typed_res.empty_set = 1'b1;
        check_explicit = (expected_ranges.size() == 1 && expected_ranges[0] == typed_res);
        if (!check_explicit) begin
            $error("empty union expected %h actual prediction differs", typed_res);
            fail_count++;
        end

        // directed table: touching, cuts, extremes, reversed, unused kinds
        directed_rows = '{
            mk(isms_pkg::KIND_LOAD_A, 48'd1, 48'd19), mk(isms_pkg::KIND_LOAD_A, 48'd20, 48'd25),
            mk(isms_pkg::KIND_LOAD_B, 48'd5, 48'd7), mk(isms_pkg::KIND_LOAD_B, 48'd10, 48'd30),
            mk(isms_pkg::KIND_LOAD_A, 48'd9, 48'd3), mk(KIND_UNUSED, 48'd0, 48'd100),
            mk(KIND_SPARE, ID_MAX, ID_MAX),
            mk(isms_pkg::KIND_DIFF, '0, '0), mk(isms_pkg::KIND_UNION, '0, '0),
            mk(isms_pkg::KIND_LOAD_A, '0, '0), mk(isms_pkg::KIND_LOAD_A, ID_MAX, ID_MAX),
            mk(isms_pkg::KIND_LOAD_B, '0, ID_MAX), mk(isms_pkg::KIND_DIFF, ID_MAX, '0),
            mk(isms_pkg::KIND_UNION, '0, '0), mk(isms_pkg::KIND_CLEAR, '0, '0),
            mk(isms_pkg::KIND_LOAD_A, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA),
            mk(isms_pkg::KIND_DIFF, '0, '0), mk(isms_pkg::KIND_CLEAR, '0, '0)
        };
        foreach (directed_rows[r]) send_command(directed_rows[r]);
        // overflow: seventeen disjoint loads into a, then emit
        for (int k = 0; k < CAP + 1; k++)
            send_command(mk(isms_pkg::KIND_LOAD_A, 48'(k * 4), 48'(k * 4 + 1)));
        send_command(mk(isms_pkg::KIND_DIFF, '0, '0));
        send_command(mk(isms_pkg::KIND_CLEAR, '0, '0));

        // random part in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 69 : 0;
            for (int item = 0; item < 80; ) begin
                phase_sel = $urandom_range(19, 0);
                base = ($urandom_range(3, 0) == 0) ? ID_MAX - IW'(300)
                                                   : IW'($urandom_range(200, 0));
                if (phase_sel < 17) begin
                    // well-formed batch: a few loads then an emit
                    for (int k = $urandom_range(10, 0); k > 0; k--) begin
                        send_command(random_load(base)); item++;
                    end
                    send_command(mk($urandom_range(1, 0) ? isms_pkg::KIND_DIFF
                                                         : isms_pkg::KIND_UNION,
                                    rand_id(), rand_id()));
                    item++;
                    if ($urandom_range(2, 0) == 0) begin
                        send_command(mk(isms_pkg::KIND_CLEAR, rand_id(), rand_id()));
                        item++;
                    end
                end else begin
                    // noise: any kind, any fields
                    send_command(mk(3'($urandom_range(7, 0)), rand_id(), rand_id()));
                    item++;
                end
            end
        end
        start <= 1'b0;

        while (expected_ranges.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
